// ----- hdl/bsfg_pkg.sv -----
// Shared types and constants of the battery sample filter and gauge.
package bsfg_pkg;

  // Width of one ADC sample and of every threshold register
  localparam int unsigned SampleBits = 12;

  // Margin above the low threshold that allows the low flag to clear
  localparam logic [SampleBits:0] ClearLowMargin = (SampleBits + 1)'(15);

  // Countdown load value of the external full-charge timer
  localparam int unsigned ChargeTimerLoad = 3600;

  // Divide-by-three as multiply by reciprocal; exact for sums below 2**17
  localparam int unsigned Div3Shift = 17;
  localparam logic [15:0] Div3Recip = 16'd43691;

  // Charger status code that reports charge complete
  localparam logic [2:0] StatusChargeDone = 3'd2;

  // Configuration register map
  typedef enum logic [2:0] {
    CfgGaugeQuarter      = 3'd0,
    CfgGaugeHalf         = 3'd1,
    CfgGaugeThreeQuarter = 3'd2,
    CfgGaugeFull         = 3'd3,
    CfgDrainLimit        = 3'd4,
    CfgLowThreshold      = 3'd5,
    CfgFullThreshold     = 3'd6,
    CfgSprayThreshold    = 3'd7
  } cfg_reg_e;

  // One input item
  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic                  restart;
    logic                  usb_present;
    logic                  timer_running;
    logic                  charge_timeout;
    logic [2:0]            charger_status;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [SampleBits-1:0] voltage;
    logic [2:0]            level;
    logic                  low_battery;
    logic                  clear_low_ok;
    logic                  spray_ok;
    logic                  full_charged;
    logic                  filter_done;
    logic                  want_sample;
    logic                  start_timer;
    logic                  stop_timer;
    logic                  show_full;
  } out_item_t;

endpackage

// ----- hdl/battery_sample_filter_gauge.sv -----
// Battery sample filter with gauge level, low/spray/full flags and timer commands.
//
// Usage: ADC samples enter on the input channel (in_valid_i / in_stall_o /
// in_data_i), one per item, together with the restart request and the
// charger and timer pin levels. Each accepted item yields exactly one result
// item on the output channel (out_valid_o / out_stall_i / out_data_o).
// Thresholds are set through the write port (cfg_we_i, cfg_idx_i,
// cfg_data_i) while no item is in flight; the countdown itself (load value
// ChargeTimerLoad) lives outside and is driven by start_timer / stop_timer.
// Timing: an item is captured in the input register at acceptance; its
// result is written to the output register when the result stage fires,
// which raises out_valid_o; the result is held there until it is taken.
// Throughput: one item per cycle while out_stall_i is low. The grouping
// tree, the divide-by-three multiply and the gauge compares form the single
// logic stage between the input register and the output register.
// Reset clears the sampled flag, group position, voltage, full flag and both
// valid bits and loads the default thresholds; the first sample afterwards
// is taken as the voltage directly.
// A stalled result holds; the input register then still takes one more item,
// after which in_stall_o follows out_stall_i.
module battery_sample_filter_gauge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  bsfg_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output bsfg_pkg::out_item_t                out_data_o,
  input  logic                               cfg_we_i,
  input  logic [2:0]                         cfg_idx_i,
  input  logic [bsfg_pkg::SampleBits-1:0]    cfg_data_i
);
  import bsfg_pkg::*;

  localparam int unsigned SumBits  = SampleBits + 2;
  localparam int unsigned ProdBits = SumBits + 16;

  // Configuration registers
  logic [SampleBits-1:0] quarter_q, half_q, three_q, gfull_q;
  logic [SampleBits-1:0] drain_q, low_thr_q, full_thr_q, spray_thr_q;

  // Filter state
  logic                  sampled_q, sampled_d;
  logic [1:0]            grp_idx_q, grp_idx_d;
  logic [SampleBits-1:0] grp0_q, grp1_q;
  logic [SampleBits-1:0] volt_q, volt_d;
  logic                  full_q, full_d;

  // Pipeline registers
  logic      s1_valid_q;
  in_item_t  s1_q;
  logic      out_valid_q;
  out_item_t out_q, out_d;

  logic s1_fire;
  logic direct, complete;

  logic [SampleBits-1:0] a, b, c, d, pick;
  logic [SumBits-1:0]    sum3;
  logic [ProdBits-1:0]   prod3;
  logic [SampleBits-1:0] avg3, avg_ab, avg_ac, avg_bc;
  logic [SampleBits:0]   sum_ab, sum_ac, sum_bc;
  logic [SampleBits:0]   clr_level;

  // Handshake: result stage advances when the output is free or being taken
  assign s1_fire     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !s1_fire;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Classify the item in the result stage
  assign direct = s1_q.restart || !sampled_q;

  always_comb begin
    unique case (grp_idx_q)
      2'd0, 2'd1: complete = 1'b0;
      default:    complete = !direct;
    endcase
  end

  // Group samples; the third one is the item itself
  assign a = grp0_q;
  assign b = grp1_q;
  assign c = s1_q.sample;
  assign d = drain_q;

  // Averages
  assign sum3   = SumBits'(a) + SumBits'(b) + SumBits'(c);
  assign prod3  = ProdBits'(sum3) * ProdBits'(Div3Recip);
  assign avg3   = prod3[Div3Shift +: SampleBits];
  assign sum_ab = (SampleBits + 1)'(a) + (SampleBits + 1)'(b);
  assign sum_ac = (SampleBits + 1)'(a) + (SampleBits + 1)'(c);
  assign sum_bc = (SampleBits + 1)'(b) + (SampleBits + 1)'(c);
  assign avg_ab = sum_ab[SampleBits:1];
  assign avg_ac = sum_ac[SampleBits:1];
  assign avg_bc = sum_bc[SampleBits:1];

  // Decision tree over the three group samples
  always_comb begin
    if (a < quarter_q || b < quarter_q || c < quarter_q) begin
      pick = avg3;
    end else if (b <= a) begin
      if (a - b <= d) begin
        if (c <= b) begin
          pick = (b - c <= d) ? avg3 : avg_ab;
        end else if (c <= a) begin
          pick = avg3;
        end else begin
          pick = (c - a > d) ? c : avg3;
        end
      end else if (c <= b) begin
        pick = a;
      end else if (c <= a) begin
        pick = (a - c > d) ? a : avg_ac;
      end else begin
        pick = (c - a <= d) ? avg_ac : c;
      end
    end else if (b - a <= d) begin
      if (c > b) begin
        pick = (c - b <= d) ? avg3 : c;
      end else if (a > c) begin
        pick = (a - c <= d) ? avg3 : avg_ab;
      end else begin
        pick = avg3;
      end
    end else if (c > b) begin
      pick = (c - b <= d) ? avg_bc : c;
    end else if (a > c) begin
      pick = b;
    end else begin
      pick = (b - c <= d) ? avg_bc : b;
    end
  end

  // Next state and result
  assign clr_level = (SampleBits + 1)'(low_thr_q) + ClearLowMargin;

  always_comb begin
    sampled_d = sampled_q;
    grp_idx_d = grp_idx_q;
    volt_d    = volt_q;
    full_d    = full_q;
    out_d     = '0;

    if (direct) begin
      sampled_d = 1'b1;
      volt_d    = s1_q.sample;
    end else if (complete) begin
      grp_idx_d = 2'd0;
      volt_d    = pick;
      full_d    = (pick > full_thr_q) && s1_q.usb_present;
      out_d.filter_done = 1'b1;
      out_d.start_timer = (pick >= full_thr_q) && !s1_q.timer_running &&
                          !s1_q.charge_timeout;
      out_d.stop_timer  = (pick < full_thr_q) && s1_q.timer_running;
      out_d.show_full   = s1_q.charge_timeout ||
                          (s1_q.charger_status == StatusChargeDone);
    end else begin
      grp_idx_d         = grp_idx_q + 2'd1;
      out_d.want_sample = 1'b1;
    end

    out_d.voltage      = volt_d;
    out_d.full_charged = full_d;
    if (volt_d < quarter_q) begin
      out_d.level = 3'd0;
    end else if (volt_d < half_q) begin
      out_d.level = 3'd1;
    end else if (volt_d < three_q) begin
      out_d.level = 3'd2;
    end else if (volt_d < gfull_q) begin
      out_d.level = 3'd3;
    end else begin
      out_d.level = 3'd4;
    end
    out_d.low_battery  = (low_thr_q != '0) && (volt_d <= low_thr_q);
    out_d.clear_low_ok = (low_thr_q != '0) && ((SampleBits + 1)'(volt_d) >= clr_level);
    out_d.spray_ok     = volt_d >= spray_thr_q;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quarter_q   <= SampleBits'(2048);
      half_q      <= SampleBits'(2304);
      three_q     <= SampleBits'(2560);
      gfull_q     <= SampleBits'(2816);
      drain_q     <= SampleBits'(16);
      low_thr_q   <= SampleBits'(2048);
      full_thr_q  <= SampleBits'(2880);
      spray_thr_q <= SampleBits'(2700);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgGaugeQuarter:      quarter_q   <= cfg_data_i;
        CfgGaugeHalf:         half_q      <= cfg_data_i;
        CfgGaugeThreeQuarter: three_q     <= cfg_data_i;
        CfgGaugeFull:         gfull_q     <= cfg_data_i;
        CfgDrainLimit:        drain_q     <= cfg_data_i;
        CfgLowThreshold:      low_thr_q   <= cfg_data_i;
        CfgFullThreshold:     full_thr_q  <= cfg_data_i;
        CfgSprayThreshold:    spray_thr_q <= cfg_data_i;
        default:              quarter_q   <= quarter_q;
      endcase
    end
  end

  // Control state and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sampled_q   <= 1'b0;
      grp_idx_q   <= 2'd0;
      volt_q      <= '0;
      full_q      <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        sampled_q   <= sampled_d;
        grp_idx_q   <= grp_idx_d;
        volt_q      <= volt_d;
        full_q      <= full_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= in_data_i;
    end
    if (s1_fire) begin
      out_q <= out_d;
      if (!direct && grp_idx_q == 2'd0) begin
        grp0_q <= s1_q.sample;
      end
      if (!direct && grp_idx_q == 2'd1) begin
        grp1_q <= s1_q.sample;
      end
    end
  end

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_idx_q != 2'd3)
    else $error("group position out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && complete |=> grp_idx_q == 2'd0)
    else $error("group position not cleared after a full group");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.start_timer && out_q.stop_timer))
    else $error("start and stop timer both set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.start_timer || out_q.stop_timer || out_q.show_full)
      |-> out_q.filter_done)
    else $error("timer command without a finished group");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.filter_done && out_q.want_sample) && out_q.level <= 3'd4)
    else $error("inconsistent result flags or level");

endmodule
